[design/min_cost_assignment_solver_macros.svh]
// Assertion helpers used by min_cost_assignment_solver.sv
`ifndef MIN_COST_ASSIGNMENT_SOLVER_MACROS_SVH
`define MIN_COST_ASSIGNMENT_SOLVER_MACROS_SVH

// same-cycle implication
`define MCA_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define MCA_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

[design/mca_pkg.sv]
`default_nettype none
package mca_pkg;
  localparam int MAX_DIM    = 32;
  localparam int COST_WIDTH = 16;
  localparam int IN_W       = 6;
  localparam int IDX_W      = $clog2(MAX_DIM + 1);
  localparam int CNT_W      = $clog2(MAX_DIM + 2);
  localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM);
  localparam int POT_W      = 32;
  localparam logic signed [POT_W-1:0] SLACK_INF = POT_W'(32'h3f3f3f3f);

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ROW_INIT, OP_SCAN_BEGIN, OP_SCAN, OP_UPD,
    OP_NEXT, OP_AUG, OP_EMIT, OP_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] col;
    logic             issue;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic match_zero;
    logic prev_zero;
  } dp_stat_t;
endpackage
`default_nettype wire

[design/mca_ram.sv]
`default_nettype none
module mca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

[design/mca_dp.sv]
`default_nettype none
module mca_dp import mca_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [IN_W-1:0]          wr_row,
  input  wire logic [IN_W-1:0]          wr_col,
  input  wire logic signed [15:0]       wr_cost,
  input  wire dp_cmd_t                  cmd,
  output dp_stat_t                      stat,
  output logic                          out_valid,
  output logic [IN_W-1:0]               out_column,
  output logic [IN_W-1:0]               out_assigned_row,
  output logic signed [31:0]            out_total_cost,
  output logic                          out_status,
  output logic                          out_last_result
);
  // column 0 holds the row being placed; its potential and match live outside the column arrays
  logic signed [POT_W-1:0] rpot_r  [1:MAX_DIM];
  logic signed [POT_W-1:0] cpot_r  [1:MAX_DIM];
  logic signed [POT_W-1:0] slack_r [1:MAX_DIM];
  logic [IDX_W-1:0]        match_r [1:MAX_DIM];
  logic [IDX_W-1:0]        back_r  [1:MAX_DIM];
  logic signed [POT_W-1:0] cpot0_r;
  logic [IDX_W-1:0]        match0_r;
  logic [MAX_DIM:0]        vis_r;
  logic [IDX_W-1:0]        cur_r, row_r, next_r, pend_col_r;
  logic signed [POT_W-1:0] delta_r;
  logic                    found_r, pend_v_r;

  logic                    in_range;
  logic [ADDR_W-1:0]       waddr, raddr;
  logic [COST_WIDTH-1:0]   rdata;
  logic signed [POT_W-1:0] c_val, new_slack;
  logic                    better, take;
  logic [IDX_W-1:0]        match_cur, back_cur, match_back, match_upd;

  assign in_range = (wr_row >= IN_W'(1)) && (int'(wr_row) <= MAX_DIM) &&
                    (wr_col >= IN_W'(1)) && (int'(wr_col) <= MAX_DIM);
  assign waddr = ADDR_W'((int'(wr_row) - 1) * MAX_DIM + (int'(wr_col) - 1));
  assign raddr = ADDR_W'((int'(row_r) - 1) * MAX_DIM + (int'(cmd.col) - 1));

  mca_ram #(.WIDTH(COST_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_cost_ram (
    .clk   (clk),
    .we    (wr_en && in_range),
    .waddr (waddr),
    .wdata (wr_cost[COST_WIDTH-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign match_cur  = (cur_r == '0) ? match0_r : match_r[cur_r];
  assign back_cur   = back_r[cur_r];
  assign match_back = (back_cur == '0) ? match0_r : match_r[back_cur];
  assign match_upd  = (cmd.col == '0) ? match0_r : match_r[cmd.col];

  // slack of the column whose cost word just came back from the store
  assign c_val = POT_W'(signed'(rdata)) - rpot_r[row_r] - cpot_r[pend_col_r];
  assign better = c_val < slack_r[pend_col_r];
  assign new_slack = better ? c_val : slack_r[pend_col_r];
  assign take = !vis_r[pend_col_r] && (!found_r || (new_slack < delta_r));

  assign stat.match_zero = (match_cur == '0);
  assign stat.prev_zero  = (back_cur == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend_v_r  <= (cmd.op == OP_SCAN) && cmd.issue;
      out_valid <= (cmd.op == OP_EMIT) || (cmd.op == OP_ERR);
    end
    if (cmd.op == OP_SCAN) begin
      pend_col_r <= cmd.col;
    end
    if (pend_v_r && !vis_r[pend_col_r]) begin
      if (better) begin
        slack_r[pend_col_r] <= c_val;
        back_r[pend_col_r]  <= cur_r;
      end
      if (take) begin
        delta_r <= new_slack;
        next_r  <= pend_col_r;
        found_r <= 1'b1;
      end
    end
    case (cmd.op)
      OP_CLEAR: begin
        cpot0_r  <= '0;
        match0_r <= '0;
        for (int k = 1; k <= MAX_DIM; k++) begin
          rpot_r[k]  <= '0;
          cpot_r[k]  <= '0;
          match_r[k] <= '0;
        end
      end
      OP_ROW_INIT: begin
        match0_r <= cmd.col;
        for (int k = 1; k <= MAX_DIM; k++) begin
          slack_r[k] <= SLACK_INF;
        end
        vis_r <= '0;
        cur_r <= '0;
      end
      OP_SCAN_BEGIN: begin
        vis_r[cur_r] <= 1'b1;
        row_r   <= match_cur;
        found_r <= 1'b0;
        delta_r <= SLACK_INF;
      end
      OP_UPD: begin
        if (vis_r[cmd.col]) begin
          rpot_r[match_upd] <= rpot_r[match_upd] + delta_r;
          if (cmd.col == '0) begin
            cpot0_r <= cpot0_r - delta_r;
          end else begin
            cpot_r[cmd.col] <= cpot_r[cmd.col] - delta_r;
          end
        end else begin
          slack_r[cmd.col] <= slack_r[cmd.col] - delta_r;
        end
      end
      OP_NEXT: begin
        cur_r <= next_r;
      end
      OP_AUG: begin
        match_r[cur_r] <= match_back;
        cur_r <= back_cur;
      end
      OP_EMIT: begin
        out_column       <= IN_W'(cmd.col);
        out_assigned_row <= IN_W'(match_r[cmd.col]);
        out_total_cost   <= 32'(-cpot0_r);
        out_status       <= 1'b0;
        out_last_result  <= cmd.last;
      end
      OP_ERR: begin
        out_column       <= '0;
        out_assigned_row <= '0;
        out_total_cost   <= '0;
        out_status       <= 1'b1;
        out_last_result  <= 1'b1;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[design/mca_ctrl.sv]
`default_nettype none
module mca_ctrl import mca_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic            solve_req,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [IN_W-1:0] cfg_data,
  input  wire dp_stat_t        stat,
  output dp_cmd_t              cmd,
  output logic                 busy
);
  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_CLEAR, S_ROW_INIT, S_SCAN_BEGIN, S_SCAN, S_UPD,
    S_NEXT, S_CHECK, S_AUG, S_EMIT
  } state_t;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  state_t           state_r;
  logic [IN_W-1:0]  rows_cfg_r, cols_cfg_r;
  logic [IDX_W-1:0] row_i_r, n_eff, m_eff;
  logic [CNT_W-1:0] j_r;

  function automatic logic [IDX_W-1:0] eff_dim(input logic [IN_W-1:0] v);
    if (v == '0) return IDX_W'(1);
    if (int'(v) > MAX_DIM) return IDX_W'(MAX_DIM);
    return IDX_W'(v);
  endfunction

  assign n_eff = eff_dim(rows_cfg_r);
  assign m_eff = eff_dim(cols_cfg_r);

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.col   = IDX_W'(j_r);
    cmd.issue = 1'b0;
    cmd.last  = (CNT_W'(m_eff) == j_r);
    unique case (state_r)
      S_ERR:        cmd.op = OP_ERR;
      S_CLEAR:      cmd.op = OP_CLEAR;
      S_ROW_INIT: begin
        cmd.op  = OP_ROW_INIT;
        cmd.col = row_i_r;
      end
      S_SCAN_BEGIN: cmd.op = OP_SCAN_BEGIN;
      S_SCAN: begin
        cmd.op    = OP_SCAN;
        cmd.issue = (j_r <= CNT_W'(m_eff));
      end
      S_UPD:        cmd.op = OP_UPD;
      S_NEXT:       cmd.op = OP_NEXT;
      S_AUG:        cmd.op = OP_AUG;
      S_EMIT:       cmd.op = OP_EMIT;
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      busy       <= 1'b0;
      rows_cfg_r <= IN_W'(32);
      cols_cfg_r <= IN_W'(32);
      row_i_r    <= '0;
      j_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS: rows_cfg_r <= cfg_data;
          CFG_COLS: cols_cfg_r <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && solve_req) begin
            busy    <= 1'b1;
            state_r <= (n_eff > m_eff) ? S_ERR : S_CLEAR;
          end
        end
        S_ERR: begin
          busy    <= 1'b0;
          state_r <= S_IDLE;
        end
        S_CLEAR: begin
          row_i_r <= IDX_W'(1);
          state_r <= S_ROW_INIT;
        end
        S_ROW_INIT: state_r <= S_SCAN_BEGIN;
        S_SCAN_BEGIN: begin
          j_r     <= CNT_W'(1);
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // j runs one past m_eff with no read issued, draining the last registered read
          if (j_r == CNT_W'(m_eff) + CNT_W'(1)) begin
            j_r     <= '0;
            state_r <= S_UPD;
          end else begin
            j_r <= j_r + CNT_W'(1);
          end
        end
        S_UPD: begin
          if (j_r == CNT_W'(m_eff)) begin
            state_r <= S_NEXT;
          end else begin
            j_r <= j_r + CNT_W'(1);
          end
        end
        S_NEXT: state_r <= S_CHECK;
        S_CHECK: state_r <= stat.match_zero ? S_AUG : S_SCAN_BEGIN;
        S_AUG: begin
          if (stat.prev_zero) begin
            if (row_i_r == n_eff) begin
              j_r     <= CNT_W'(1);
              state_r <= S_EMIT;
            end else begin
              row_i_r <= row_i_r + IDX_W'(1);
              state_r <= S_ROW_INIT;
            end
          end
        end
        S_EMIT: begin
          if (j_r == CNT_W'(m_eff)) begin
            busy    <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            j_r <= j_r + CNT_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/min_cost_assignment_solver.sv]
// Channel   Transfer when        Payload
// in        start && !busy       in_row_index, in_col_index, in_cost, in_start_solve
// out       out_valid            out_column, out_assigned_row, out_total_cost,
//                                out_status, out_last_result
// cfg       cfg_we               cfg_index, cfg_data
//
// A solve runs one clear step, then per row one init step and per path step a scan
// over the cost RAM read port, a potential update pass over columns 0..m and 3
// control steps, followed by augment steps walking back along the path. Results
// then leave one per cycle, m in a row; an error produces a single result.
// Synchronous active-low reset; no clearing pass. Results cannot be stalled.
`default_nettype none
`include "min_cost_assignment_solver_macros.svh"
module min_cost_assignment_solver import mca_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [5:0]         in_row_index,
  input  wire logic [5:0]         in_col_index,
  input  wire logic signed [15:0] in_cost,
  input  wire logic               in_start_solve,
  output logic                    out_valid,
  output logic [5:0]              out_column,
  output logic [5:0]              out_assigned_row,
  output logic signed [31:0]      out_total_cost,
  output logic                    out_status,
  output logic                    out_last_result,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [5:0]         cfg_data
);
  logic     accept;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign accept = start && !busy;

  mca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .solve_req (in_start_solve),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  mca_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_en            (accept),
    .wr_row           (in_row_index),
    .wr_col           (in_col_index),
    .wr_cost          (in_cost),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_column       (out_column),
    .out_assigned_row (out_assigned_row),
    .out_total_cost   (out_total_cost),
    .out_status       (out_status),
    .out_last_result  (out_last_result)
  );

  `MCA_ASSERT_NEXT(a_solve_goes_busy, clk, rst_n, accept && in_start_solve, busy, "busy missing")
  `MCA_ASSERT_NOW(a_err_is_last, clk, rst_n, out_valid && out_status, out_last_result, "error not last")
  `MCA_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_last_result, !out_valid, "extra")
endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
module testbench;
  import mca_pkg::*;

  localparam bit REG_ROWS = 1'b0;
  localparam bit REG_COLS = 1'b1;
  localparam bit STAT_SOLVED = 1'b0;
  localparam bit STAT_ROWS_EXCEED = 1'b1;
  localparam longint SLACK_BIG = 64'sd1 << 62;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] cost;
    logic               go;
  } entry_t;

  typedef struct {
    logic [5:0]         column;
    logic [5:0]         row;
    logic signed [31:0] total;
    logic               status;
    logic               is_last;
  } match_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [5:0] in_row_index = '0;
  logic [5:0] in_col_index = '0;
  logic signed [15:0] in_cost = '0;
  logic in_start_solve = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [5:0] cfg_data = '0;
  logic busy, out_valid, out_status, out_last_result;
  logic [5:0] out_column, out_assigned_row;
  logic signed [31:0] out_total_cost;

  min_cost_assignment_solver dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  entry_t load_q[$];
  match_t match_q[$];
  longint cost_mem[MAX_DIM * MAX_DIM];
  bit written[MAX_DIM * MAX_DIM];
  int sent = 0;
  logic [5:0] rows_reg = 6'd32;
  logic [5:0] cols_reg = 6'd32;
  int errors = 0;
  int idle_cycles = 0;

  function automatic int clamp_dim(logic [5:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // shortest augmenting path with row/column potentials
  function automatic void solve_assignment();
    int n, m, cur, r, nxt;
    longint rp[0:32], cp[0:32], slack[0:32];
    int owner[0:32], back[0:32];
    bit seen[0:32];
    bit found;
    longint delta, c, total;
    match_t e;
    n = clamp_dim(rows_reg);
    m = clamp_dim(cols_reg);
    if (n > m) begin
      e = '{6'd0, 6'd0, 32'sd0, STAT_ROWS_EXCEED, 1'b1};
      match_q.insert(match_q.size(), e);
      return;
    end
    for (int j = 0; j <= MAX_DIM; j++) begin
      rp[j] = 0; cp[j] = 0; owner[j] = 0; back[j] = 0;
    end
    for (int i = 1; i <= n; i++) begin
      cur = 0;
      owner[0] = i;
      for (int j = 0; j <= MAX_DIM; j++) begin
        slack[j] = SLACK_BIG;
        seen[j] = 1'b0;
      end
      do begin
        seen[cur] = 1'b1;
        r = owner[cur];
        found = 1'b0;
        delta = SLACK_BIG;
        nxt = 0;
        for (int j = 1; j <= m; j++) begin
          if (!seen[j]) begin
            c = cost_mem[(r - 1) * MAX_DIM + (j - 1)] - rp[r] - cp[j];
            if (c < slack[j]) begin
              slack[j] = c;
              back[j] = cur;
            end
            if (!found || slack[j] < delta) begin
              delta = slack[j];
              nxt = j;
              found = 1'b1;
            end
          end
        end
        for (int j = 0; j <= m; j++) begin
          if (seen[j]) begin
            rp[owner[j]] += delta;
            cp[j] -= delta;
          end else begin
            slack[j] -= delta;
          end
        end
        cur = nxt;
      end while (owner[cur] != 0);
      do begin
        r = back[cur];
        owner[cur] = owner[r];
        cur = r;
      end while (cur != 0);
    end
    total = -cp[0];
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    for (int j = 1; j <= m; j++) begin
      e = '{6'(j), 6'(owner[j]), 32'(total), STAT_SOLVED, j == m};
      match_q.insert(match_q.size(), e);
    end
  endfunction

  // input transfers feed the predictor; results are checked against it
  always @(posedge clk) begin
    entry_t it;
    match_t e;
    if (out_valid) begin
      if (match_q.size() == 0) begin
        $error("unexpected result column %0d", out_column);
        errors++;
      end else begin
        e = match_q.pop_front();
        if (out_column !== e.column) begin
          $error("column exp %0d got %0d", e.column, out_column); errors++;
        end
        if (out_assigned_row !== e.row) begin
          $error("assigned_row exp %0d got %0d", e.row, out_assigned_row); errors++;
        end
        if (out_total_cost !== e.total) begin
          $error("total_cost exp %0d got %0d", e.total, out_total_cost); errors++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_last_result !== e.is_last) begin
          $error("last_result exp %0d got %0d", e.is_last, out_last_result); errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      it = load_q.pop_front();
      if (it.row >= 1 && it.row <= MAX_DIM && it.col >= 1 && it.col <= MAX_DIM)
        cost_mem[(it.row - 1) * MAX_DIM + (it.col - 1)] = it.cost;
      if (it.go) solve_assignment();
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // sender: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n || load_q.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else begin
      start <= 1'b1;
      in_row_index <= load_q[0].row;
      in_col_index <= load_q[0].col;
      in_cost <= load_q[0].cost;
      in_start_solve <= load_q[0].go;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  function automatic logic signed [15:0] pick_cost(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 7));
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  function automatic void push_entry(int r, int c, logic signed [15:0] v, bit go);
    entry_t it;
    it = '{6'(r), 6'(c), v, go};
    load_q.insert(load_q.size(), it);
    sent++;
    if (r >= 1 && r <= MAX_DIM && c >= 1 && c <= MAX_DIM)
      written[(r - 1) * MAX_DIM + (c - 1)] = 1'b1;
  endfunction

  // every entry of the n-by-m area has been loaded at least once
  function automatic bit area_written(int n, int m);
    for (int r = 1; r <= n; r++)
      for (int c = 1; c <= m; c++)
        if (!written[(r - 1) * MAX_DIM + (c - 1)]) return 1'b0;
    return 1'b1;
  endfunction

  // full n-by-m matrix, solve on the final entry
  function automatic void push_matrix(int n, int m, int mode);
    for (int r = 1; r <= n; r++)
      for (int c = 1; c <= m; c++)
        push_entry(r, c, pick_cost(mode), r == n && c == m);
  endfunction

  task automatic drain();
    wait (load_q.size() == 0 && match_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, logic [5:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROWS) rows_reg = v;
    else rows_reg = rows_reg;
    if (idx == REG_COLS) cols_reg = v;
  endtask

  task automatic set_dims(logic [5:0] n, logic [5:0] m);
    write_reg(REG_ROWS, n);
    write_reg(REG_COLS, m);
  endtask

  initial begin
    int n, m, mode;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // column count still at its reset value of 32: one full row, random full-range costs
    write_reg(REG_ROWS, 6'd1);
    push_matrix(1, 32, 0);
    drain();
    set_dims(6'd40, 6'd3);                // rows clamp to 32 and exceed columns
    push_entry(2, 2, -16'sd5, 1'b1);
    drain();
    set_dims(6'd1, 6'd63);                // columns clamp to 32
    push_entry(1, 5, 16'sh7fff, 1'b1);
    drain();
    set_dims(6'd0, 6'd0);                 // both count as one
    push_entry(32, 32, 16'sh2aaa, 1'b1);
    drain();
    set_dims(6'd1, 6'd1);
    push_entry(1, 1, 16'sh8000, 1'b1);
    drain();
    set_dims(6'd2, 6'd3);
    push_matrix(2, 3, 2);
    push_entry(0, 63, 16'sh7fff, 1'b1);   // dropped index, still solves
    push_entry(33, 2, 16'sh1234, 1'b0);
    push_entry(1, 0, 16'sh5555, 1'b1);
    drain();
    set_dims(6'd4, 6'd4);
    push_matrix(4, 4, 1);
    drain();

    while (sent < 145) begin
      n = $urandom_range(1, 4);
      m = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : $urandom_range(n, 6);
      mode = $urandom_range(0, 3);
      set_dims(6'(n), 6'(m));
      if ($urandom_range(0, 2) == 0 && area_written(n, m)) begin
        // partial rewrite plus stray out-of-range entries
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 4) == 0)
            push_entry($urandom_range(0, 1) ? 0 : $urandom_range(33, 63),
                       $urandom_range(0, 63), pick_cost(0), 1'b0);
          else
            push_entry($urandom_range(1, n), $urandom_range(1, m), pick_cost(mode), 1'b0);
        end
        push_entry($urandom_range(1, 32), $urandom_range(1, 32), pick_cost(mode), 1'b1);
      end else begin
        push_matrix(n, m, mode);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+design
design/mca_pkg.sv
design/mca_ram.sv
design/mca_dp.sv
design/mca_ctrl.sv
design/min_cost_assignment_solver.sv
test/testbench.sv
